// ===== src/wcg_pkg.sv =====
// Shared types and constants for the window coefficient generator.
package wcg_pkg;

	// Window type codes held in the type register.
	localparam logic [2:0] WT_RECT  = 3'd0;
	localparam logic [2:0] WT_BART  = 3'd1;
	localparam logic [2:0] WT_HANN  = 3'd2;
	localparam logic [2:0] WT_HAMM  = 3'd3;
	localparam logic [2:0] WT_BLACK = 3'd4;

	// Register select, taken from paddr[2].
	localparam logic REG_TYPE   = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	localparam logic [2:0]  TYPE_RESET   = WT_HANN;
	localparam logic [16:0] LENGTH_RESET = 17'd1024;

	// Phase in Q30 units of pi.
	localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
	localparam logic [31:0] Q30_HALF = 32'h2000_0000;
	localparam logic [31:0] Q30_TWO  = 32'h8000_0000;
	localparam logic [63:0] Q30_RND  = 64'h0000_0000_2000_0000;

	// Odd Taylor terms of sin(pi*u), Q30.
	localparam logic [32:0] SC1  = 33'd3373259426;
	localparam logic [32:0] SC3  = 33'd5548789346;
	localparam logic [32:0] SC5  = 33'd2738217788;
	localparam logic [32:0] SC7  = 33'd643455389;
	localparam logic [32:0] SC9  = 33'd88203474;
	localparam logic [32:0] SC11 = 33'd7913940;

	localparam logic [32:0] HORNER_C [0:4] = '{SC9, SC7, SC5, SC3, SC1};

	typedef struct packed {
		logic       inv;
		logic [2:0] wtype;
		logic       mzero;
	} side_t;

endpackage

// ===== src/window_coefficient_generator_top.sv =====
// Window coefficient generator: pipelined divider, cosine lanes and window sum.
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_stall  sample_index
//  coef      out        coef_valid / coef_stall      coefficient, index_invalid
//  config    in         APB psel/penable/pready      paddr, pwdata, prdata
//
// One item enters per clock while sample_stall is low.
// The restoring divider has 31 stages with one quotient bit each.
// Reset selects Hann with length 1024 and empties the pipeline.
// While a result waits with coef_stall high, every stage holds and sample_stall is high.
module window_coefficient_generator_top
	import wcg_pkg::*;
#(
	parameter int INDEX_BITS     = 16,
	parameter int COEF_FRAC_BITS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic [INDEX_BITS-1:0] sample_index,
	output logic                  coef_valid,
	input  logic                  coef_stall,
	output logic [15:0]           coefficient,
	output logic                  index_invalid
);

	localparam int F   = COEF_FRAC_BITS;
	localparam int NW  = 48;
	localparam int QW  = 31;
	localparam int NST = 44;
	localparam int XW  = ((INDEX_BITS > 17) ? INDEX_BITS : 17) + 1;
	localparam int BW  = F + 8;
	localparam int MW  = F + 1;
	localparam int TW  = F + 24;
	localparam int PW  = BW + MW;
	localparam int VW  = F + 2;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << (F + 7)) / 64'd100);
	localparam logic [31:0]   ONE32 = 32'd1 << F;
	localparam logic [VW-1:0] ONE_V = VW'(ONE32);

	// Configuration registers.
	logic [2:0]  wtype_q;
	logic [16:0] wlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wtype_q <= TYPE_RESET;
			wlen_q  <= LENGTH_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_LENGTH) begin
				wlen_q <= pwdata[16:0];
			end else begin
				wtype_q <= pwdata[2:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_LENGTH) ? 32'(wlen_q) : 32'(wtype_q);
	assign pready = 1'b1;

	// Pipeline control.
	logic adv;
	logic acc;
	logic valid_s [1:NST];

	assign coef_valid   = valid_s[NST];
	assign adv          = !valid_s[NST] || !coef_stall;
	assign sample_stall = !adv;
	assign acc          = sample_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else if (adv) begin
			valid_s[1] <= acc;
			for (int i = 2; i <= NST; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	// Entry: distance from the centre, divisor and numerator.
	logic [XW-1:0] idx_x, m_x, k_x;
	logic [16:0]   k_e, d_e, m_e;
	logic [NW-1:0] num_e;
	side_t         side_e;

	always_comb begin
		idx_x = XW'(sample_index);
		m_x   = XW'(wlen_q[16:1]);
		k_x   = (idx_x > m_x) ? (idx_x - m_x) : (m_x - idx_x);
		k_e   = k_x[16:0];
		m_e   = 17'(wlen_q[16:1]);
		d_e   = (wtype_q == WT_HANN) ? (m_e + 17'd1) : m_e;
		if (wtype_q == WT_BART) begin
			num_e = (NW'(m_e - k_e) << F) + NW'(m_e >> 1);
		end else begin
			num_e = (NW'(k_e) << 30) + NW'(d_e >> 1);
		end
		side_e.inv   = idx_x >= XW'(wlen_q);
		side_e.wtype = wtype_q;
		side_e.mzero = (m_e == 17'd0);
	end

	logic [NW-1:0] rem_s  [1:32];
	logic [QW-1:0] quo_s  [1:32];
	logic [16:0]   d_s    [1:32];
	side_t         side_s [1:NST];

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[1]  <= num_e;
			quo_s[1]  <= '0;
			d_s[1]    <= d_e;
			side_s[1] <= side_e;
			for (int i = 2; i <= NST; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Restoring divider, one quotient bit per stage.
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int B = QW - 1 - j;
		logic [NW-1:0] trial;
		logic          ge;

		assign trial = NW'(d_s[j+1]) << B;
		assign ge    = rem_s[j+1] >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+2] <= ge ? (rem_s[j+1] - trial) : rem_s[j+1];
				quo_s[j+2] <= {quo_s[j+1][QW-2:0], ge};
				d_s[j+2]   <= d_s[j+1];
			end
		end
	end

	// Cosine lanes: lane 0 takes the phase, lane 1 twice the phase folded into [0, pi].
	logic [59:0] sq_s34 [0:1];
	logic [62:0] prod_s [35:40][0:1];
	logic signed [17:0] c_s41 [0:1];
	logic [15:0] bart_s [33:43];

	logic [31:0] xc, x2;
	logic [31:0] y_l [0:1];

	always_comb begin
		xc     = (32'(quo_s[32]) > Q30_ONE) ? Q30_ONE : 32'(quo_s[32]);
		x2     = xc << 1;
		y_l[0] = xc;
		y_l[1] = (x2 > Q30_ONE) ? (Q30_TWO - x2) : x2;
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [29:0] u_s   [33:39];
		logic        neg_s [33:40];
		logic [29:0] s_s   [35:38];
		logic [29:0] s_new;
		logic [32:0] r_fin;
		logic [19:0] r_q16;
		logic [16:0] r_sat;

		always_comb begin
			s_new = 30'((64'(sq_s34[l]) + Q30_RND) >> 30);
			r_fin = 33'((64'(prod_s[40][l]) + Q30_RND) >> 30);
			r_q16 = 20'((34'(r_fin) + 34'd8192) >> 14);
			r_sat = (r_q16 > 20'd65536) ? 17'd65536 : r_q16[16:0];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				u_s[33]       <= (y_l[l] <= Q30_HALF) ? 30'(Q30_HALF - y_l[l])
				                                      : 30'(y_l[l] - Q30_HALF);
				neg_s[33]     <= y_l[l] > Q30_HALF;
				sq_s34[l]     <= 60'(u_s[33]) * 60'(u_s[33]);
				s_s[35]       <= s_new;
				prod_s[35][l] <= 63'(SC11) * 63'(s_new);
				for (int i = 34; i <= 39; i++) begin
					u_s[i] <= u_s[i-1];
				end
				for (int i = 34; i <= 40; i++) begin
					neg_s[i] <= neg_s[i-1];
				end
				for (int i = 36; i <= 38; i++) begin
					s_s[i] <= s_s[i-1];
				end
				c_s41[l] <= neg_s[40] ? -signed'({1'b0, r_sat}) : signed'({1'b0, r_sat});
			end
		end

		// Horner steps of the sine polynomial.
		for (genvar h = 0; h < 5; h++) begin : g_horner
			logic [32:0] rnd, p;
			logic [29:0] op;

			assign rnd = 33'((64'(prod_s[35+h][l]) + Q30_RND) >> 30);
			assign p   = HORNER_C[h] - rnd;
			if (h < 4) begin : g_sq
				assign op = s_s[35+h];
			end else begin : g_u
				assign op = u_s[35+h];
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s[36+h][l] <= 63'(p) * 63'(op);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bart_s[33] <= quo_s[32][15:0];
			for (int i = 34; i <= 43; i++) begin
				bart_s[i] <= bart_s[i-1];
			end
		end
	end

	// Window sum in hundredths, scaled by 2^16.
	logic signed [24:0] ca, cb, t_new;
	logic signed [24:0] t_s42;

	always_comb begin
		ca = 25'(c_s41[0]);
		cb = 25'(c_s41[1]);
		unique case (side_s[41].wtype)
			WT_HANN:  t_new = 25'sd3276800 + ca * 25'sd50;
			WT_HAMM:  t_new = 25'sd3538944 + ca * 25'sd46;
			WT_BLACK: t_new = 25'sd2752512 + ca * 25'sd50 + cb * 25'sd8;
			default:  t_new = '0;
		endcase
	end

	// Scaling to COEF_FRAC_BITS: divide by 100 through a reciprocal product.
	logic          pos_new;
	logic [TW-1:0] tw;
	logic [BW-1:0] b_new;
	logic          pos_s43;
	logic [BW-1:0] b_s43;
	logic [PW-1:0] pb_s43;

	always_comb begin
		pos_new = !t_s42[24] && (t_s42 != 25'sd0);
		tw      = (TW'(t_s42[23:0]) << F) + TW'(3276800);
		b_new   = tw[TW-1:16];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s42   <= t_new;
			pos_s43 <= pos_new;
			b_s43   <= b_new;
			pb_s43  <= PW'(b_new) * PW'(RECIP);
		end
	end

	logic [VW-1:0] q0, v;
	logic [BW-1:0] rem100;
	logic [31:0]   sel;
	logic [15:0]   coef_s44;

	always_comb begin
		q0     = VW'(pb_s43 >> (F + 7));
		rem100 = b_s43 - BW'(BW'(q0) * BW'(100));
		v      = q0 + VW'(rem100 >= BW'(100));
		if (!pos_s43) begin
			v = '0;
		end else if (v > ONE_V) begin
			v = ONE_V;
		end
		if (side_s[43].inv) begin
			sel = '0;
		end else if (side_s[43].mzero) begin
			sel = ONE32;
		end else begin
			unique case (side_s[43].wtype)
				WT_BART:                   sel = 32'(bart_s[43]);
				WT_HANN, WT_HAMM, WT_BLACK: sel = 32'(v);
				default:                   sel = ONE32;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_s44 <= sel[15:0];
		end
	end

	assign coefficient   = coef_s44;
	assign index_invalid = side_s[NST].inv;

`ifndef ASSERT_OFF
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && index_invalid |-> coefficient == 16'd0)
		else $error("invalid index gave a non-zero coefficient");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> coef_valid && coef_stall)
		else $error("input stalled without a waiting result");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> valid_s[1])
		else $error("accepted transfer did not enter the pipeline");
`endif

endmodule
